FILE: rtl/vtlbf_pkg.sv
// Package: shared types and constants of the vertical three-tap line buffer filter.
`timescale 1ns / 1ps

package vtlbf_pkg;

    // Field and register widths
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;

    // Parameter defaults
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    // Register reset value for both frame registers
    localparam logic [CFG_W-1:0] CFG_RESET_VAL = 11'd1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Per-beat control decided by the front end
    typedef struct packed {
        logic sel;      // 1: write store b, above from b, centre from a
        logic top;      // first image row is the centre: above := centre
        logic bottom;   // flush row: below := centre
        logic eol;      // last column of the row
        logic eof;      // last output pixel of the frame
        logic emit;     // beat produces a result
    } t_job_ctl;

endpackage

FILE: rtl/vertical_three_tap_line_buffer_filter.sv
// Top level: vertical 1-2-1 smoothing filter with two alternating line stores.
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  ----------------------------------
//  in        sink       i_in_valid / o_in_ready      i_pixel_in
//  out       source     o_out_valid / i_out_ready    o_pixel_out, o_end_of_line,
//                                                    o_end_of_frame
//  cfg       sink       i_cfg_wr_en (no wait)        i_cfg_index, i_cfg_data
//
//  One pixel beat per cycle sustained unless the output stalls; an accepted beat passes
//  the queue, the line store read and the output register on its way to its result.
//  The single read/write port of each line store, used once per beat, sets the rate.
//  Reset is synchronous, active low; line stores are not cleared and need no pass.
//  A four-entry queue decouples the counters from the stores, so input keeps
//  flowing for a few beats while the output stalls.
`timescale 1ns / 1ps

module vertical_three_tap_line_buffer_filter
    import vtlbf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PIX_W-1:0]     i_pixel_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_pixel_out,
    output logic                 o_end_of_line,
    output logic                 o_end_of_frame
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int CTL_W = $bits(t_job_ctl);
    localparam int JOB_W = CTL_W + CW + PIX_W;

    logic             w_push, w_pop, w_q_full, w_q_nonempty;
    t_job_ctl         w_f_ctl, w_b_ctl;
    logic [CW-1:0]    w_f_col, w_b_col;
    logic [PIX_W-1:0] w_f_pix, w_b_pix;
    logic [JOB_W-1:0] w_q_in, w_q_out;

    vtlbf_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel_in  (i_pixel_in),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_ctl       (w_f_ctl),
        .o_col       (w_f_col),
        .o_pix       (w_f_pix)
    );

    // Pack and unpack a queued job
    assign w_q_in = {w_f_ctl, w_f_col, w_f_pix};
    assign {w_b_ctl, w_b_col, w_b_pix} = w_q_out;

    vtlbf_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_q_in),
        .i_pop      (w_pop),
        .o_data     (w_q_out),
        .o_full     (w_q_full),
        .o_nonempty (w_q_nonempty)
    );

    vtlbf_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nonempty   (w_q_nonempty),
        .i_ctl          (w_b_ctl),
        .i_col          (w_b_col),
        .i_pix          (w_b_pix),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame)
    );

    // The back end never pops an empty queue
    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_nonempty)
        else $error("pop from empty job queue");

    // A frame ends only on the last column of a row
    a_eof_on_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_frame) |-> o_end_of_line)
        else $error("end of frame without end of line");

    // No result is shown in the cycle after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

FILE: rtl/vtlbf_front.sv
// Front end: frame registers, row and column counters, beat classification.
`timescale 1ns / 1ps

module vtlbf_front
    import vtlbf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [PIX_W-1:0]             i_pixel_in,
    input  logic                         i_q_full,
    output logic                         o_push,
    output t_job_ctl                     o_ctl,
    output logic [$clog2(MAX_COLS)-1:0]  o_col,
    output logic [PIX_W-1:0]             o_pix
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int XW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int YW = (RW > CFG_W) ? RW : CFG_W;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic             r_sel, n_sel;

    logic [XW-1:0]    w_width_raw, w_width;
    logic [YW-1:0]    w_height_raw, w_height;
    logic             w_last, w_bottom, w_accept;

    // Write the frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_RESET_VAL;
            r_frame_height <= CFG_RESET_VAL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the registers into their usable range
    always_comb begin
        w_width_raw  = XW'(r_frame_width);
        w_height_raw = YW'(r_frame_height);
        if (w_width_raw == '0)
            w_width = XW'(1);
        else if (w_width_raw > XW'(MAX_COLS))
            w_width = XW'(MAX_COLS);
        else
            w_width = w_width_raw;
        if (w_height_raw == '0)
            w_height = YW'(1);
        else if (w_height_raw > YW'(MAX_ROWS))
            w_height = YW'(MAX_ROWS);
        else
            w_height = w_height_raw;
    end

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    assign o_push     = w_accept;

    // Classify the beat and work out the next counter values
    always_comb begin
        w_last   = (XW'(r_col) + XW'(1)) >= w_width;
        w_bottom = YW'(r_row) >= w_height;
        n_sel    = (r_col == '0) ? !r_sel : r_sel;
        if (w_last) begin
            n_col = '0;
            n_row = w_bottom ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
        o_ctl.sel    = n_sel;
        o_ctl.top    = (r_row == RW'(1));
        o_ctl.bottom = w_bottom;
        o_ctl.eol    = w_last;
        o_ctl.eof    = w_last && w_bottom;
        o_ctl.emit   = (r_row != '0);
        o_col        = r_col;
        o_pix        = i_pixel_in;
    end

    // Advance the counters on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sel <= 1'b1;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_sel <= n_sel;
        end
    end

endmodule

FILE: rtl/vtlbf_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module vtlbf_queue
    import vtlbf_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_nonempty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_slot [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [NW-1:0]     r_count;

    assign o_full     = (r_count == NW'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_slot[r_rd_ptr];

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_slot[r_wr_ptr] <= i_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            if (i_push && !i_pop)
                r_count <= r_count + NW'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - NW'(1);
        end
    end

endmodule

FILE: rtl/vtlbf_back.sv
// Back end: the two line stores, the 1-2-1 vertical filter and the output register.
`timescale 1ns / 1ps

module vtlbf_back
    import vtlbf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_nonempty,
    input  t_job_ctl                     i_ctl,
    input  logic [$clog2(MAX_COLS)-1:0]  i_col,
    input  logic [PIX_W-1:0]             i_pix,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [PIX_W-1:0]             o_pixel_out,
    output logic                         o_end_of_line,
    output logic                         o_end_of_frame
);

    localparam int SW = PIX_W + 2;

    logic [PIX_W-1:0] r_store_a [MAX_COLS];
    logic [PIX_W-1:0] r_store_b [MAX_COLS];
    logic [PIX_W-1:0] r_rd_a, r_rd_b;

    logic             r_m_valid;
    t_job_ctl         r_m_ctl;
    logic [PIX_W-1:0] r_m_pix;

    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_pix;
    logic             r_o_eol, r_o_eof;

    logic             w_m_adv;
    logic [PIX_W-1:0] w_above, w_centre, w_below;
    logic [SW-1:0]    w_sum;

    // Move the memory stage on when its beat needs no output slot or one is free
    assign w_m_adv = r_m_valid && (!r_m_ctl.emit || !r_o_valid || i_out_ready);
    assign o_pop   = i_q_nonempty && (!r_m_valid || w_m_adv);

    // Line store a: read the old entry, write the new pixel when selected
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_a <= r_store_a[i_col];
            if (!i_ctl.sel)
                r_store_a[i_col] <= i_pix;
        end
    end

    // Line store b: read the old entry, write the new pixel when selected
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_b <= r_store_b[i_col];
            if (i_ctl.sel)
                r_store_b[i_col] <= i_pix;
        end
    end

    // Hold the job alongside its read data
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_ctl <= i_ctl;
            r_m_pix <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_m_valid <= 1'b0;
        else if (o_pop)
            r_m_valid <= 1'b1;
        else if (w_m_adv)
            r_m_valid <= 1'b0;
    end

    // Pick the three taps, apply edge rules, sum with weights 1-2-1
    always_comb begin
        w_above  = r_m_ctl.sel ? r_rd_b : r_rd_a;
        w_centre = r_m_ctl.sel ? r_rd_a : r_rd_b;
        w_below  = r_m_pix;
        if (r_m_ctl.top)
            w_above = w_centre;
        if (r_m_ctl.bottom)
            w_below = w_centre;
        w_sum = SW'(w_above) + {1'b0, w_centre, 1'b0} + SW'(w_below);
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_o_valid <= 1'b0;
        else if (w_m_adv && r_m_ctl.emit)
            r_o_valid <= 1'b1;
        else if (i_out_ready)
            r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_m_adv && r_m_ctl.emit) begin
            r_o_pix <= w_sum[SW-1:2];
            r_o_eol <= r_m_ctl.eol;
            r_o_eof <= r_m_ctl.eof;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_pixel_out    = r_o_pix;
    assign o_end_of_line  = r_o_eol;
    assign o_end_of_frame = r_o_eof;

endmodule

FILE: tb/vertical_three_tap_line_buffer_filter_test.sv
// Testbench: self-checking stimulus and line-buffer predictor for the vertical 1-2-1 filter.
`timescale 1ns / 1ps

module vertical_three_tap_line_buffer_filter_test;
    import vtlbf_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int BATCH_ITEMS   = 375;
    localparam int REPORT_LIMIT  = 40;

    // One filtered pixel as it leaves the block
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eol;
        logic             eof;
    } t_smoothed;

    localparam t_smoothed NO_PIXEL = '0;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_SET_WIDTH,
        STEP_SET_HEIGHT
    } t_step_kind;

    typedef struct {
        t_step_kind     kind;
        logic [CFG_W-1:0] value;
        bit             typed;
        t_smoothed      want;
    } t_step;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [PIX_W-1:0]     i_pixel_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [PIX_W-1:0]     o_pixel_out;
    logic                 o_end_of_line;
    logic                 o_end_of_frame;

    vertical_three_tap_line_buffer_filter DUT (.*);

    // Predictor state: two line stores, row/column position, store select, registers
    logic [PIX_W-1:0] line_a [DEF_MAX_COLS];
    logic [PIX_W-1:0] line_b [DEF_MAX_COLS];
    logic             write_b;
    logic [CFG_W-1:0] row_idx;
    logic [9:0]       col_idx;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    t_smoothed smoothed_q [$];
    t_smoothed got_pixel;
    t_smoothed want_pixel;
    int        errors = 0;
    int        cycle_count = 0;
    int        in_idle_pct;
    int        out_stall_pct;

    // Directed frames: edge rules, register clamping, mid-frame shrinks
    t_step directed_plan [32] = '{
        '{STEP_SET_WIDTH,  11'd2,    1'b0, NO_PIXEL},
        '{STEP_SET_HEIGHT, 11'd1,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd0,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd255,  1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd17,   1'b1, '{8'd0,   1'b0, 1'b0}},
        '{STEP_PIXEL,      11'd200,  1'b1, '{8'd255, 1'b1, 1'b1}},
        '{STEP_SET_WIDTH,  11'd0,    1'b0, NO_PIXEL},
        '{STEP_SET_HEIGHT, 11'd0,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd255,  1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd0,    1'b1, '{8'd255, 1'b1, 1'b1}},
        '{STEP_SET_WIDTH,  11'd1,    1'b0, NO_PIXEL},
        '{STEP_SET_HEIGHT, 11'd3,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd255,  1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd0,    1'b1, '{8'd191, 1'b1, 1'b0}},
        '{STEP_PIXEL,      11'd255,  1'b1, '{8'd127, 1'b1, 1'b0}},
        '{STEP_PIXEL,      11'd0,    1'b1, '{8'd191, 1'b1, 1'b1}},
        '{STEP_SET_HEIGHT, 11'd4,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd10,   1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd20,   1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd30,   1'b0, NO_PIXEL},
        '{STEP_SET_HEIGHT, 11'd2,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd40,   1'b0, NO_PIXEL},
        '{STEP_SET_WIDTH,  11'd4,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd1,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd2,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd3,    1'b0, NO_PIXEL},
        '{STEP_SET_WIDTH,  11'd2,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd4,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd5,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd6,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd7,    1'b0, NO_PIXEL},
        '{STEP_PIXEL,      11'd8,    1'b0, NO_PIXEL}
    };

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Register value as the block uses it: zero reads as one, overflow as the maximum
    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    // Advance the line stores by one pixel and work out the filtered pixel, if any
    task automatic smooth_column(input logic [PIX_W-1:0] pix, output bit has_out,
                                 output t_smoothed res);
        int  w;
        int  h;
        int  c;
        int  above;
        int  centre;
        int  below;
        bit  last_col;
        bit  bottom;
        w = clamp_dim(width_reg, DEF_MAX_COLS);
        h = clamp_dim(height_reg, DEF_MAX_ROWS);
        c = int'(col_idx);
        if (c >= DEF_MAX_COLS)
            c = DEF_MAX_COLS - 1;
        if (c == 0)
            write_b = ~write_b;
        // read both rows before the write of this column
        if (write_b) begin
            above = line_b[c];
            centre = line_a[c];
            line_b[c] = pix;
        end else begin
            above = line_a[c];
            centre = line_b[c];
            line_a[c] = pix;
        end
        below = pix;
        bottom = int'(row_idx) >= h;
        if (row_idx == 1)
            above = centre;
        if (bottom)
            below = centre;
        last_col = (c + 1) >= w;
        has_out = row_idx != 0;
        res.pixel = PIX_W'((above + 2 * centre + below) >> 2);
        res.eol = last_col;
        res.eof = last_col && bottom;
        if (last_col) begin
            col_idx = '0;
            row_idx = bottom ? '0 : row_idx + 1'b1;
        end else begin
            col_idx = 10'(c + 1);
        end
    endtask

    // Present one pixel beat, hold it until accepted, then predict its result
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                              input t_smoothed want);
        bit        has_out;
        t_smoothed res;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= pix;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        smooth_column(pix, has_out, res);
        if (typed)
            smoothed_q.push_back(want);
        else if (has_out)
            smoothed_q.push_back(res);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every result, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (smoothed_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one or both frame registers back to back
    task automatic write_regs(input bit set_w, input logic [CFG_W-1:0] w,
                              input bit set_h, input logic [CFG_W-1:0] h);
        if (set_w) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_FRAME_WIDTH;
            i_cfg_data <= w;
            @(negedge i_clk);
            width_reg = w;
        end
        if (set_h) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_FRAME_HEIGHT;
            i_cfg_data <= h;
            @(negedge i_clk);
            height_reg = h;
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 70)
            return CFG_W'($urandom_range(8, 1));
        return CFG_W'($urandom_range(40, 9));
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 75)
            return CFG_W'($urandom_range(5, 1));
        return CFG_W'($urandom_range(16, 6));
    endfunction

    // Run one frame including its flush row; optionally shrink the width or change the height part-way
    task automatic run_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                             input bit allow_break, output int items);
        int total;
        int break_at;
        settle();
        write_regs(1'b1, w_val, 1'b1, h_val);
        total = clamp_dim(w_val, DEF_MAX_COLS) * (clamp_dim(h_val, DEF_MAX_ROWS) + 1);
        break_at = -1;
        if (allow_break && total > 1 && $urandom_range(99) < 20)
            break_at = $urandom_range(total - 1, 1);
        items = 0;
        do begin
            if (items == break_at) begin
                settle();
                // width may only shrink mid-frame; height may go either way
                if ($urandom_range(1))
                    write_regs(1'b1, CFG_W'($urandom_range(clamp_dim(width_reg,
                               DEF_MAX_COLS))), 1'b0, '0);
                else
                    write_regs(1'b0, '0, 1'b1, CFG_W'($urandom_range(clamp_dim(height_reg,
                               DEF_MAX_ROWS) + 3)));
            end
            send_pixel(rand_pixel(), 1'b0, NO_PIXEL);
            items++;
        end while (row_idx != 0 || col_idx != 0);
    endtask

    // Receiver back-pressure
    always @(negedge i_clk)
        i_out_ready <= $urandom_range(99) >= out_stall_pct;

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_pixel = '{o_pixel_out, o_end_of_line, o_end_of_frame};
            if (smoothed_q.size() == 0) begin
                if (errors < REPORT_LIMIT)
                    $display("%0t: unexpected beat: pixel %0d eol %0b eof %0b", $time,
                             got_pixel.pixel, got_pixel.eol, got_pixel.eof);
                errors++;
            end else begin
                want_pixel = smoothed_q.pop_front();
                if (got_pixel !== want_pixel) begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t: expected %0d eol %0b eof %0b, got %0d eol %0b eof %0b",
                                 $time, want_pixel.pixel, want_pixel.eol, want_pixel.eof,
                                 got_pixel.pixel, got_pixel.eol, got_pixel.eof);
                    errors++;
                end
            end
        end
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int batch;
        int items;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_FRAME_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_pixel_in = '0;
        i_out_ready = 1'b0;
        in_idle_pct = 25;
        out_stall_pct = 74;
        write_b = 1'b1;
        row_idx = '0;
        col_idx = '0;
        width_reg = CFG_RESET_VAL;
        height_reg = CFG_RESET_VAL;
        for (int i = 0; i < DEF_MAX_COLS; i++) begin
            line_a[i] = '0;
            line_b[i] = '0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_plan[i]) begin
            case (directed_plan[i].kind)
                STEP_PIXEL: begin
                    send_pixel(directed_plan[i].value[PIX_W-1:0], directed_plan[i].typed,
                               directed_plan[i].want);
                end
                STEP_SET_WIDTH: begin
                    settle();
                    write_regs(1'b1, directed_plan[i].value, 1'b0, '0);
                end
                STEP_SET_HEIGHT: begin
                    settle();
                    write_regs(1'b0, '0, 1'b1, directed_plan[i].value);
                end
                default: begin
                end
            endcase
        end

        // Random frames under three idling patterns
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    in_idle_pct = 25;
                    out_stall_pct = 74;
                end
                1: begin
                    in_idle_pct = 74;
                    out_stall_pct = 25;
                end
                default: begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
            endcase
            batch = 0;
            while (batch < BATCH_ITEMS) begin
                run_frame(pick_width(), pick_height(), 1'b1, items);
                batch += items;
            end
        end

        // Drain and let the last beats leave
        i_in_valid <= 1'b0;
        while (smoothed_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
